// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/spmix_pkg.sv =====
package spmix_pkg;

  // Frame shape
  localparam int CHANNELS  = 4;
  localparam int SAMPLE_W  = 16;
  localparam int CTL_W     = 32;
  localparam int SETUP_W   = 26;
  localparam int KNOB_W    = 13;
  localparam int MIX_W     = 19;

  // Q12 scale
  localparam int Q_ONE     = 4096;
  localparam int Q_SHIFT   = 12;

  // CV gain: clamp(cv, 0, 10 V) * 4096 / 10240 == (c * CV_RECIP) >> CV_SHIFT
  localparam int CV_FULL   = 10240;
  localparam int CV_W      = 14;
  localparam int CV_RECIP  = 26215;
  localparam int CV_SHIFT  = 16;
  localparam int CVP_W     = CV_W + 15;
  localparam int GAIN_W    = 13;

  // Pan CV: floor(4 * pcv / 5) taken on pcv + PAN_OFS, which keeps it positive
  localparam int PAN_OFS   = 32770;
  localparam int PAN_IN_W  = 17;
  localparam int PAN_RECIP = 838861;
  localparam int PAN_SHIFT = 20;
  localparam int PANP_W    = PAN_IN_W + 20;
  localparam int PAN_BIAS  = 26216;
  localparam int PAN_SUM_W = 18;

  // Datapath widths
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int PART_P_W  = SAMPLE_W + KNOB_W + 1;
  localparam int PART_W    = 18;
  localparam int SUM_W     = PART_W + $clog2(CHANNELS);
  localparam int MIX_P_W   = SUM_W + GAIN_W + 1;

  localparam int DIRECT_MAX = 32767;
  localparam int DIRECT_MIN = -32768;
  localparam int MIX_MAX    = 262143;
  localparam int MIX_MIN    = -262144;

  // Register map
  localparam int IDX_W      = $clog2(CHANNELS + 1);
  localparam logic [IDX_W-1:0] IDX_MASTER = IDX_W'(CHANNELS);
  localparam logic [SETUP_W-1:0] SETUP_RST  = 26'h1000000;
  localparam logic [KNOB_W-1:0]  MASTER_RST = 13'd2048;

  // Pipeline: four lane stages, three merge stages
  localparam int STAGES = 7;

  typedef struct packed {
    logic [STAGES:1] ld;
  } pipe_ctl_t;

  // Clamp a CV to 0..10 V
  function automatic logic [CV_W-1:0] cv_clamp(input logic signed [SAMPLE_W-1:0] v);
    logic [CV_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > CV_FULL) begin
      c = CV_W'(CV_FULL);
    end else begin
      c = v[CV_W-1:0];
    end
    return c;
  endfunction

endpackage

// ===== design/four_channel_stereo_pan_mixer_top.sv =====
// Four-channel stereo mixer with linear pan.
//
// Input channel: one word per audio frame (four samples, four control words
// holding volume and pan CVs, one master CV), moved on in_valid with in_stall.
// Output channel: one word per input word (left/right mix, four direct
// channel outputs), moved on out_valid with out_stall.
// Config port: cfg_wr_en writes cfg_wdata to register cfg_index (strips 0..3,
// then master level); other indexes are ignored. Write only while idle.
//
// Four lane stages per channel (CV gain, channel gain and pan, gain
// multiply, saturate and pan split) and three merge stages (sum, master
// multiply, saturate into the output register) lie between accept and
// out_valid. Throughput is one word per cycle while out_stall is low; each
// stage carries its own valid bit, so bubbles close up while the output is
// stalled, and in_stall rises only when all seven stages hold words and out_stall is high.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// knob registers: volumes 0, pans centered, master at one half.
`include "assert_macros.svh"

module four_channel_stereo_pan_mixer_top (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] in_sample_b,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] in_sample_c,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] in_sample_d,
  input  logic        [spmix_pkg::CTL_W-1:0]    in_controls_a,
  input  logic        [spmix_pkg::CTL_W-1:0]    in_controls_b,
  input  logic        [spmix_pkg::CTL_W-1:0]    in_controls_c,
  input  logic        [spmix_pkg::CTL_W-1:0]    in_controls_d,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] in_master_cv,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [spmix_pkg::MIX_W-1:0]    out_mix_left,
  output logic signed [spmix_pkg::MIX_W-1:0]    out_mix_right,
  output logic signed [spmix_pkg::SAMPLE_W-1:0] out_direct_a,
  output logic signed [spmix_pkg::SAMPLE_W-1:0] out_direct_b,
  output logic signed [spmix_pkg::SAMPLE_W-1:0] out_direct_c,
  output logic signed [spmix_pkg::SAMPLE_W-1:0] out_direct_d,

  input  logic                                  cfg_wr_en,
  input  logic        [spmix_pkg::IDX_W-1:0]    cfg_index,
  input  logic        [spmix_pkg::SETUP_W-1:0]  cfg_wdata
);

  logic [spmix_pkg::SETUP_W-1:0]  setup_r [spmix_pkg::CHANNELS];
  logic [spmix_pkg::KNOB_W-1:0]   master_r;

  logic [spmix_pkg::STAGES:1]     v_r, v_nxt;
  logic [spmix_pkg::STAGES+1:1]   rdy;
  spmix_pkg::pipe_ctl_t           ctl;

  logic signed [spmix_pkg::SAMPLE_W-1:0] samp     [spmix_pkg::CHANNELS];
  logic        [spmix_pkg::CTL_W-1:0]    ctls     [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::SAMPLE_W-1:0] dir      [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::PART_W-1:0]   lpart    [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::PART_W-1:0]   rpart    [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::SAMPLE_W-1:0] dir_out  [spmix_pkg::CHANNELS];

  // Knob registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spmix_pkg::CHANNELS; i++) begin
        setup_r[i] <= spmix_pkg::SETUP_RST;
      end
      master_r <= spmix_pkg::MASTER_RST;
    end else if (cfg_wr_en) begin
      for (int i = 0; i < spmix_pkg::CHANNELS; i++) begin
        if (cfg_index == spmix_pkg::IDX_W'(i)) begin
          setup_r[i] <= cfg_wdata;
        end
      end
      if (cfg_index == spmix_pkg::IDX_MASTER) begin
        master_r <= cfg_wdata[spmix_pkg::KNOB_W-1:0];
      end
    end
  end

  // Stage valids: a stage loads when it is empty or its word moves on
  always_comb begin
    rdy[spmix_pkg::STAGES+1] = !out_stall;
    for (int k = spmix_pkg::STAGES; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[1] = rdy[1] ? in_valid : v_r[1];
    for (int k = 2; k <= spmix_pkg::STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
    ctl.ld = rdy[spmix_pkg::STAGES:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[spmix_pkg::STAGES];

  // Gather the per-channel ports
  assign samp[0] = in_sample_a;
  assign samp[1] = in_sample_b;
  assign samp[2] = in_sample_c;
  assign samp[3] = in_sample_d;
  assign ctls[0] = in_controls_a;
  assign ctls[1] = in_controls_b;
  assign ctls[2] = in_controls_c;
  assign ctls[3] = in_controls_d;

  // One lane per channel
  for (genvar g = 0; g < spmix_pkg::CHANNELS; g++) begin : g_lane
    spmix_lane u_lane (
      .clk        (clk),
      .ctl        (ctl),
      .sample     (samp[g]),
      .controls   (ctls[g]),
      .setup      (setup_r[g]),
      .direct     (dir[g]),
      .left_part  (lpart[g]),
      .right_part (rpart[g])
    );
  end

  spmix_merge u_merge (
    .clk          (clk),
    .ctl          (ctl),
    .master_cv    (in_master_cv),
    .master_level (master_r),
    .direct       (dir),
    .lpart        (lpart),
    .rpart        (rpart),
    .mix_left     (out_mix_left),
    .mix_right    (out_mix_right),
    .direct_out   (dir_out)
  );

  assign out_direct_a = dir_out[0];
  assign out_direct_b = dir_out[1];
  assign out_direct_c = dir_out[2];
  assign out_direct_d = dir_out[3];

  // Checks
  `ASSERT_ON(a_accept_fills_s1, in_valid && !in_stall |=> v_r[1], "accepted word lost at stage 1")
  `ASSERT_ON(a_stall_only_full, in_stall |-> (&v_r) && out_stall, "input stalled with room in pipe")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

// ===== design/spmix_lane.sv =====
module spmix_lane (
  input  logic                                  clk,
  input  spmix_pkg::pipe_ctl_t                  ctl,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] sample,
  input  logic        [spmix_pkg::CTL_W-1:0]    controls,
  input  logic        [spmix_pkg::SETUP_W-1:0]  setup,
  output logic signed [spmix_pkg::SAMPLE_W-1:0] direct,
  output logic signed [spmix_pkg::PART_W-1:0]   left_part,
  output logic signed [spmix_pkg::PART_W-1:0]   right_part
);

  logic signed [spmix_pkg::SAMPLE_W-1:0]  vcv, pcv;
  logic        [spmix_pkg::CV_W-1:0]      cv_c;
  logic        [spmix_pkg::PAN_SUM_W-1:0] pan_wide;
  logic        [spmix_pkg::PAN_IN_W-1:0]  pan_in;

  logic signed [spmix_pkg::SAMPLE_W-1:0]  s1_samp_r, s2_samp_r;
  logic        [spmix_pkg::CVP_W-1:0]     s1_cvp_r;
  logic        [spmix_pkg::PANP_W-1:0]    s1_panp_r;

  logic        [spmix_pkg::KNOB_W-1:0]    vknob, pknob, cvg;
  logic        [2*spmix_pkg::KNOB_W-1:0]  gain_p;
  logic        [spmix_pkg::PAN_IN_W-1:0]  pan_off;
  logic signed [spmix_pkg::PAN_SUM_W-1:0] pan_sum;
  logic        [spmix_pkg::KNOB_W-1:0]    pan_nxt;
  logic        [spmix_pkg::GAIN_W-1:0]    s2_gain_r;
  logic        [spmix_pkg::KNOB_W-1:0]    s2_pan_r, s3_pan_r;

  logic signed [spmix_pkg::PROD_W-1:0]    s3_prod_r;
  logic signed [spmix_pkg::PROD_W-spmix_pkg::Q_SHIFT-1:0] scaled;
  logic signed [spmix_pkg::SAMPLE_W-1:0]  dir_nxt;
  logic        [spmix_pkg::KNOB_W-1:0]    wl;

  logic signed [spmix_pkg::SAMPLE_W-1:0]  s4_dir_r;
  logic signed [spmix_pkg::PART_P_W-1:0]  s4_lp_r, s4_rp_r;

  // Stage 1: clamp CVs, start the reciprocal multiplies
  always_comb begin
    vcv      = $signed(controls[spmix_pkg::SAMPLE_W-1:0]);
    pcv      = $signed(controls[spmix_pkg::CTL_W-1:spmix_pkg::SAMPLE_W]);
    cv_c     = spmix_pkg::cv_clamp(vcv);
    pan_wide = {{(spmix_pkg::PAN_SUM_W-spmix_pkg::SAMPLE_W){pcv[spmix_pkg::SAMPLE_W-1]}}, pcv}
               + spmix_pkg::PAN_SUM_W'(spmix_pkg::PAN_OFS);
    pan_in   = pan_wide[spmix_pkg::PAN_IN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      s1_samp_r <= sample;
      s1_cvp_r  <= spmix_pkg::CVP_W'(cv_c) * spmix_pkg::CVP_W'(spmix_pkg::CV_RECIP);
      s1_panp_r <= spmix_pkg::PANP_W'(pan_in) * spmix_pkg::PANP_W'(spmix_pkg::PAN_RECIP);
    end
  end

  // Stage 2: channel gain, pan position clamped to 0..1
  always_comb begin
    vknob   = setup[spmix_pkg::KNOB_W-1:0];
    pknob   = setup[2*spmix_pkg::KNOB_W-1:spmix_pkg::KNOB_W];
    cvg     = s1_cvp_r[spmix_pkg::CV_SHIFT +: spmix_pkg::KNOB_W];
    gain_p  = (2*spmix_pkg::KNOB_W)'(vknob) * (2*spmix_pkg::KNOB_W)'(cvg);
    pan_off = s1_panp_r[spmix_pkg::PAN_SHIFT +: spmix_pkg::PAN_IN_W];
    pan_sum = $signed(spmix_pkg::PAN_SUM_W'(pan_off))
              - $signed(spmix_pkg::PAN_SUM_W'(spmix_pkg::PAN_BIAS))
              + $signed(spmix_pkg::PAN_SUM_W'(pknob));
    if (pan_sum < 0) begin
      pan_nxt = '0;
    end else if (pan_sum > spmix_pkg::Q_ONE) begin
      pan_nxt = spmix_pkg::KNOB_W'(spmix_pkg::Q_ONE);
    end else begin
      pan_nxt = pan_sum[spmix_pkg::KNOB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      s2_samp_r <= s1_samp_r;
      s2_gain_r <= gain_p[spmix_pkg::Q_SHIFT +: spmix_pkg::GAIN_W];
      s2_pan_r  <= pan_nxt;
    end
  end

  // Stage 3: sample times gain
  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      s3_prod_r <= spmix_pkg::PROD_W'(s2_samp_r) * $signed({1'b0, s2_gain_r});
      s3_pan_r  <= s2_pan_r;
    end
  end

  // Stage 4: saturate the direct word, split it by the pan law
  always_comb begin
    scaled = s3_prod_r[spmix_pkg::PROD_W-1:spmix_pkg::Q_SHIFT];
    if (scaled > spmix_pkg::DIRECT_MAX) begin
      dir_nxt = spmix_pkg::SAMPLE_W'(spmix_pkg::DIRECT_MAX);
    end else if (scaled < spmix_pkg::DIRECT_MIN) begin
      dir_nxt = spmix_pkg::SAMPLE_W'(spmix_pkg::DIRECT_MIN);
    end else begin
      dir_nxt = scaled[spmix_pkg::SAMPLE_W-1:0];
    end
    wl = spmix_pkg::KNOB_W'(spmix_pkg::Q_ONE) - s3_pan_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      s4_dir_r <= dir_nxt;
      s4_lp_r  <= spmix_pkg::PART_P_W'(dir_nxt) * $signed({1'b0, wl});
      s4_rp_r  <= spmix_pkg::PART_P_W'(dir_nxt) * $signed({1'b0, s3_pan_r});
    end
  end

  // Times two over 4096 is a shift by eleven
  assign direct     = s4_dir_r;
  assign left_part  = s4_lp_r[spmix_pkg::PART_W+spmix_pkg::Q_SHIFT-2:spmix_pkg::Q_SHIFT-1];
  assign right_part = s4_rp_r[spmix_pkg::PART_W+spmix_pkg::Q_SHIFT-2:spmix_pkg::Q_SHIFT-1];

endmodule

// ===== design/spmix_merge.sv =====
module spmix_merge (
  input  logic                                  clk,
  input  spmix_pkg::pipe_ctl_t                  ctl,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] master_cv,
  input  logic        [spmix_pkg::KNOB_W-1:0]   master_level,
  input  logic signed [spmix_pkg::SAMPLE_W-1:0] direct   [spmix_pkg::CHANNELS],
  input  logic signed [spmix_pkg::PART_W-1:0]   lpart    [spmix_pkg::CHANNELS],
  input  logic signed [spmix_pkg::PART_W-1:0]   rpart    [spmix_pkg::CHANNELS],
  output logic signed [spmix_pkg::MIX_W-1:0]    mix_left,
  output logic signed [spmix_pkg::MIX_W-1:0]    mix_right,
  output logic signed [spmix_pkg::SAMPLE_W-1:0] direct_out [spmix_pkg::CHANNELS]
);

  logic        [spmix_pkg::CVP_W-1:0]    m1_cvp_r;
  logic        [spmix_pkg::KNOB_W-1:0]   mcvg;
  logic        [2*spmix_pkg::KNOB_W-1:0] mgain_p;
  logic        [spmix_pkg::GAIN_W-1:0]   m2_gain_r, m3_gain_r, m4_gain_r, m5_gain_r;

  logic signed [spmix_pkg::SUM_W-1:0]    lsum, rsum;
  logic signed [spmix_pkg::SUM_W-1:0]    s5_lsum_r, s5_rsum_r;
  logic signed [spmix_pkg::SAMPLE_W-1:0] s5_dir_r [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::SAMPLE_W-1:0] s6_dir_r [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::SAMPLE_W-1:0] s7_dir_r [spmix_pkg::CHANNELS];
  logic signed [spmix_pkg::MIX_P_W-1:0]  s6_lp_r, s6_rp_r;
  logic signed [spmix_pkg::MIX_P_W-spmix_pkg::Q_SHIFT-1:0] lsc, rsc;
  logic signed [spmix_pkg::MIX_W-1:0]    mixl_nxt, mixr_nxt, s7_mixl_r, s7_mixr_r;

  // Master gain runs beside the lane stages and waits for the sums
  assign mcvg    = m1_cvp_r[spmix_pkg::CV_SHIFT +: spmix_pkg::KNOB_W];
  assign mgain_p = (2*spmix_pkg::KNOB_W)'(master_level) * (2*spmix_pkg::KNOB_W)'(mcvg);

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      m1_cvp_r <= spmix_pkg::CVP_W'(spmix_pkg::cv_clamp(master_cv))
                  * spmix_pkg::CVP_W'(spmix_pkg::CV_RECIP);
    end
    if (ctl.ld[2]) begin
      m2_gain_r <= mgain_p[spmix_pkg::Q_SHIFT +: spmix_pkg::GAIN_W];
    end
    if (ctl.ld[3]) begin
      m3_gain_r <= m2_gain_r;
    end
    if (ctl.ld[4]) begin
      m4_gain_r <= m3_gain_r;
    end
    if (ctl.ld[5]) begin
      m5_gain_r <= m4_gain_r;
    end
  end

  // Stage 5: add up the lane contributions
  always_comb begin
    lsum = '0;
    rsum = '0;
    for (int i = 0; i < spmix_pkg::CHANNELS; i++) begin
      lsum = lsum + spmix_pkg::SUM_W'(lpart[i]);
      rsum = rsum + spmix_pkg::SUM_W'(rpart[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      s5_lsum_r <= lsum;
      s5_rsum_r <= rsum;
      s5_dir_r  <= direct;
    end
  end

  // Stage 6: scale by master gain
  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      s6_lp_r  <= spmix_pkg::MIX_P_W'(s5_lsum_r) * $signed({1'b0, m5_gain_r});
      s6_rp_r  <= spmix_pkg::MIX_P_W'(s5_rsum_r) * $signed({1'b0, m5_gain_r});
      s6_dir_r <= s5_dir_r;
    end
  end

  // Stage 7: saturate into the output register
  always_comb begin
    lsc = s6_lp_r[spmix_pkg::MIX_P_W-1:spmix_pkg::Q_SHIFT];
    rsc = s6_rp_r[spmix_pkg::MIX_P_W-1:spmix_pkg::Q_SHIFT];
    if (lsc > spmix_pkg::MIX_MAX) begin
      mixl_nxt = spmix_pkg::MIX_W'(spmix_pkg::MIX_MAX);
    end else if (lsc < spmix_pkg::MIX_MIN) begin
      mixl_nxt = spmix_pkg::MIX_W'(spmix_pkg::MIX_MIN);
    end else begin
      mixl_nxt = lsc[spmix_pkg::MIX_W-1:0];
    end
    if (rsc > spmix_pkg::MIX_MAX) begin
      mixr_nxt = spmix_pkg::MIX_W'(spmix_pkg::MIX_MAX);
    end else if (rsc < spmix_pkg::MIX_MIN) begin
      mixr_nxt = spmix_pkg::MIX_W'(spmix_pkg::MIX_MIN);
    end else begin
      mixr_nxt = rsc[spmix_pkg::MIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[7]) begin
      s7_mixl_r <= mixl_nxt;
      s7_mixr_r <= mixr_nxt;
      s7_dir_r  <= s6_dir_r;
    end
  end

  assign mix_left   = s7_mixl_r;
  assign mix_right  = s7_mixr_r;
  assign direct_out = s7_dir_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import spmix_pkg::*;

  // Register map
  localparam logic [IDX_W-1:0] REG_STRIP_A     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MASTER      = IDX_MASTER;
  localparam int               REG_UNMAPPED_LO = CHANNELS + 1;
  localparam int               REG_UNMAPPED_HI = (1 << IDX_W) - 1;
  localparam int               STRIP_SEL_W     = $clog2(CHANNELS);

  localparam int  PAN_FULL_LSB  = 5120;
  localparam int  KNOB_MAX      = (1 << KNOB_W) - 1;
  localparam int  RANDOM_PHASES = 8;
  localparam int  PHASE_WORDS   = 195;
  localparam int  FLOOD_WORDS   = 40;
  localparam int  HOLD_CYCLES   = 300;
  localparam int  DRAIN_CYCLES  = 20;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_W-1:0] sample;
    logic [CHANNELS-1:0][CTL_W-1:0]    controls;
    logic [SAMPLE_W-1:0]               master_cv;
  } frame_t;

  typedef struct packed {
    logic [MIX_W-1:0]                  left;
    logic [MIX_W-1:0]                  right;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] direct;
  } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  frame_t in_frame = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [MIX_W-1:0]    out_mix_left;
  logic signed [MIX_W-1:0]    out_mix_right;
  logic signed [SAMPLE_W-1:0] out_direct_a;
  logic signed [SAMPLE_W-1:0] out_direct_b;
  logic signed [SAMPLE_W-1:0] out_direct_c;
  logic signed [SAMPLE_W-1:0] out_direct_d;

  logic               cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [SETUP_W-1:0] cfg_wdata = '0;

  // Shadow copy of the knob registers
  logic [SETUP_W-1:0] strip_knobs [CHANNELS];
  logic [KNOB_W-1:0]  master_knob;

  mix_t mix_pending [$];
  int   mismatches = 0;
  int   cycles = 0;

  // Traffic shaping
  int tx_idle_pct = 0;
  int rx_busy_pct = 0;
  int rx_hold_ticket = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int rx_run = 0;

  four_channel_stereo_pan_mixer_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_a  (in_frame.sample[0]),
    .in_sample_b  (in_frame.sample[1]),
    .in_sample_c  (in_frame.sample[2]),
    .in_sample_d  (in_frame.sample[3]),
    .in_controls_a(in_frame.controls[0]),
    .in_controls_b(in_frame.controls[1]),
    .in_controls_c(in_frame.controls[2]),
    .in_controls_d(in_frame.controls[3]),
    .in_master_cv (in_frame.master_cv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mix_left (out_mix_left),
    .out_mix_right(out_mix_right),
    .out_direct_a (out_direct_a),
    .out_direct_b (out_direct_b),
    .out_direct_c (out_direct_c),
    .out_direct_d (out_direct_d),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mixer arithmetic
  // ---------------------------------------------------------------------------

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // 0..10 V control voltage to a Q12 gain
  function automatic longint cv_level(input longint cv);
    return clamp(cv, 0, CV_FULL) * Q_ONE / CV_FULL;
  endfunction

  function automatic mix_t mix_frame(input frame_t f);
    mix_t   r;
    longint s, vcv, pcv, vol, pan_knob, gain, direct, num, q, pan;
    longint lsum, rsum, mgain;
    lsum = 0;
    rsum = 0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s        = longint'($signed(f.sample[ch]));
      vcv      = longint'($signed(f.controls[ch][15:0]));
      pcv      = longint'($signed(f.controls[ch][31:16]));
      vol      = longint'(strip_knobs[ch][KNOB_W-1:0]);
      pan_knob = longint'(strip_knobs[ch][SETUP_W-1:KNOB_W]);
      gain     = (vol * cv_level(vcv)) >>> Q_SHIFT;
      direct   = clamp((s * gain) >>> Q_SHIFT, DIRECT_MIN, DIRECT_MAX);
      // pan CV over 5 V, rounded toward minus infinity
      num = pcv * Q_ONE;
      q   = num / PAN_FULL_LSB;
      if ((num % PAN_FULL_LSB) != 0 && num < 0) begin
        q = q - 1;
      end
      pan  = clamp(q + pan_knob, 0, Q_ONE);
      lsum += (direct * 2 * (Q_ONE - pan)) >>> Q_SHIFT;
      rsum += (direct * 2 * pan) >>> Q_SHIFT;
      r.direct[ch] = direct[SAMPLE_W-1:0];
    end
    mgain = (longint'(master_knob) * cv_level(longint'($signed(f.master_cv)))) >>> Q_SHIFT;
    r.left  = MIX_W'(clamp((lsum * mgain) >>> Q_SHIFT, MIX_MIN, MIX_MAX));
    r.right = MIX_W'(clamp((rsum * mgain) >>> Q_SHIFT, MIX_MIN, MIX_MAX));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [SETUP_W-1:0] strip_word(input int vol, input int pan);
    logic [KNOB_W-1:0] v, p;
    v = vol[KNOB_W-1:0];
    p = pan[KNOB_W-1:0];
    return {p, v};
  endfunction

  function automatic frame_t uniform_word(input int sample, input int vol_cv,
                                          input int pan_cv, input int master_cv);
    frame_t f;
    logic [15:0] vc, pc;
    vc = vol_cv[15:0];
    pc = pan_cv[15:0];
    for (int ch = 0; ch < CHANNELS; ch++) begin
      f.sample[ch]   = sample[SAMPLE_W-1:0];
      f.controls[ch] = {pc, vc};
    end
    f.master_cv = master_cv[SAMPLE_W-1:0];
    return f;
  endfunction

  // Mostly musical values, with extremes and raw bit patterns mixed in
  function automatic int pick_sample();
    case ($urandom_range(7))
      0:       return 32767;
      1:       return -32768;
      2, 3:    return int'($urandom_range(2047)) - 1024;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_level_cv();
    case ($urandom_range(7))
      0, 1:    return CV_FULL;
      2:       return int'($urandom_range(65535)) - 32768;
      3:       return int'($urandom_range(2047)) - 2048;
      default: return int'($urandom_range(12288));
    endcase
  endfunction

  function automatic int pick_pan_cv();
    case ($urandom_range(5))
      0:       return 0;
      1:       return int'($urandom_range(65535)) - 32768;
      default: return int'($urandom_range(12288)) - 6144;
    endcase
  endfunction

  function automatic int pick_knob();
    case ($urandom_range(5))
      0:       return 0;
      1:       return Q_ONE;
      2:       return KNOB_MAX;
      3:       return int'($urandom_range(KNOB_MAX));
      default: return int'($urandom_range(Q_ONE));
    endcase
  endfunction

  function automatic frame_t random_word();
    frame_t f;
    int vc, pc;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      vc = pick_level_cv();
      pc = pick_pan_cv();
      f.sample[ch]   = SAMPLE_W'(pick_sample());
      f.controls[ch] = {pc[15:0], vc[15:0]};
    end
    f.master_cv = SAMPLE_W'(pick_level_cv());
    return f;
  endfunction

  function automatic int pick_gap(input int pct);
    if (int'($urandom_range(99)) >= pct) begin
      return 0;
    end
    return ($urandom_range(9) == 0) ? int'($urandom_range(40, 10)) : int'($urandom_range(3, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks (entered on a rising-edge step)
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [IDX_W-1:0] index, input logic [SETUP_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    if (index < REG_MASTER) begin
      strip_knobs[index[STRIP_SEL_W-1:0]] = data;
    end else if (index == REG_MASTER) begin
      master_knob = data[KNOB_W-1:0];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_word(input frame_t f);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame <= f;
    do @(posedge clk); while (in_stall);
    mix_pending.push_back(mix_frame(f));
  endtask

  // Drop valid and hold until every pending result is out
  task automatic drain();
    in_valid <= 1'b0;
    while (mix_pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_knobs(input int vol, input int pan, input int master);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      write_reg(REG_STRIP_A + IDX_W'(ch), strip_word(vol, pan));
    end
    write_reg(REG_MASTER, SETUP_W'(master));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Volumes reset to zero: every output must read zero
  task automatic test_reset_state();
    tx_idle_pct = 0;
    rx_busy_pct = 0;
    send_word(uniform_word(32767, CV_FULL, 0, CV_FULL));
    send_word(uniform_word(-32768, 32767, -32768, 32767));
    send_word(random_word());
    drain();
  endtask

  task automatic test_directed_corners();
    tx_idle_pct = 30;
    rx_busy_pct = 30;
    // hard left, boosted hard right, center, muted with pan past the end
    write_reg(REG_STRIP_A + IDX_W'(0), strip_word(Q_ONE, 0));
    write_reg(REG_STRIP_A + IDX_W'(1), strip_word(KNOB_MAX, Q_ONE));
    write_reg(REG_STRIP_A + IDX_W'(2), strip_word(Q_ONE, Q_ONE / 2));
    write_reg(REG_STRIP_A + IDX_W'(3), strip_word(0, KNOB_MAX));
    write_reg(REG_MASTER, SETUP_W'(Q_ONE));
    send_word(uniform_word(0, 0, 0, 0));
    send_word(uniform_word(32767, CV_FULL, 0, CV_FULL));
    send_word(uniform_word(-32768, CV_FULL, 0, CV_FULL));
    send_word(uniform_word(20000, -1, 0, CV_FULL));
    send_word(uniform_word(20000, 32767, 0, CV_FULL));
    send_word(uniform_word(-12345, CV_FULL, 32767, CV_FULL));
    send_word(uniform_word(12345, CV_FULL, -32768, CV_FULL));
    send_word(uniform_word(-777, 5000, -3, 7000));
    send_word(uniform_word(30000, CV_FULL, 1000, -32768));
    send_word(uniform_word(-30000, 7777, -1000, 32767));
    send_word(uniform_word(1, CV_FULL, 1, CV_FULL));
    send_word(uniform_word(-1, CV_FULL, -1, CV_FULL));
    drain();
    // volume and master knobs at maximum, pans at zero: directs and mixes both clip
    load_knobs(KNOB_MAX, 0, KNOB_MAX);
    send_word(uniform_word(32767, CV_FULL, 0, CV_FULL));
    send_word(uniform_word(-32768, CV_FULL, 0, CV_FULL));
    drain();
    write_reg(REG_MASTER, SETUP_W'(0));
    send_word(uniform_word(32767, CV_FULL, 0, CV_FULL));
    drain();
  endtask

  // Writes to indexes past the master register change nothing
  task automatic test_unmapped_index();
    load_knobs(Q_ONE, Q_ONE / 2, Q_ONE);
    for (int idx = REG_UNMAPPED_LO; idx <= REG_UNMAPPED_HI; idx++) begin
      write_reg(IDX_W'(idx), SETUP_W'($urandom()));
    end
    for (int n = 0; n < 4; n++) begin
      send_word(random_word());
    end
    drain();
  endtask

  // Long receiver hold while the sender floods the pipeline
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_busy_pct = 0;
    rx_hold_ticket++;
    for (int n = 0; n < FLOOD_WORDS; n++) begin
      send_word(random_word());
    end
    drain();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        load_knobs(KNOB_MAX, KNOB_MAX, KNOB_MAX);
      end else if (ph == 1) begin
        load_knobs(0, 0, 0);
      end else begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          write_reg(REG_STRIP_A + IDX_W'(ch), strip_word(pick_knob(), pick_knob()));
        end
        // junk in the unused upper bits must be ignored
        write_reg(REG_MASTER, {13'($urandom()), 13'(pick_knob())});
      end
      tx_idle_pct = (ph % 3 == 2) ? 0 : int'($urandom_range(60));
      rx_busy_pct = (ph % 4 == 3) ? 0 : int'($urandom_range(60));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, plus a long hold on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_ticket != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_ticket;
      rx_hold_left <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (rx_run > 0) begin
      rx_run <= rx_run - 1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < rx_busy_pct);
      rx_run    <= ($urandom_range(9) == 0) ? int'($urandom_range(40, 10))
                                            : int'($urandom_range(3));
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    mix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mix_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected word: left %0d right %0d", $realtime,
                   out_mix_left, out_mix_right);
        end
      end else begin
        want = mix_pending.pop_front();
        compare_field("mix_left", longint'($signed(want.left)), longint'(out_mix_left));
        compare_field("mix_right", longint'($signed(want.right)), longint'(out_mix_right));
        compare_field("direct_a", longint'($signed(want.direct[0])), longint'(out_direct_a));
        compare_field("direct_b", longint'($signed(want.direct[1])), longint'(out_direct_b));
        compare_field("direct_c", longint'($signed(want.direct[2])), longint'(out_direct_c));
        compare_field("direct_d", longint'($signed(want.direct[3])), longint'(out_direct_d));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      strip_knobs[ch] = SETUP_RST;
    end
    master_knob = MASTER_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_corners();
    test_unmapped_index();
    test_backpressure();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && mix_pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
